/* design/midpoint_displacement_heightmap_core_assert.svh */
// Assertion macros for the midpoint displacement height grid core.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MIDPOINT_DISPLACEMENT_HEIGHTMAP_CORE_ASSERT_SVH
`define MIDPOINT_DISPLACEMENT_HEIGHTMAP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MDH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MDH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mdh_pkg.sv */
// Shared types, constants and table builders for the height grid core.
// No dependencies; imported by the multiply-accumulate unit and the top level.
package mdh_pkg;

    localparam int GRID_SIZE   = 8;
    localparam int CW          = 3;
    localparam int ADDR_W      = 2 * CW;
    localparam int CELLS       = 1 << ADDR_W;
    localparam int H_W         = 16;
    localparam int STACK_DEPTH = 8;
    localparam int SP_W        = 4;
    localparam int OP_COUNT    = 5;
    localparam int ROOT_DEPTH  = 128;

    localparam logic [CW-1:0]  G_LAST     = CW'(GRID_SIZE - 1);
    localparam logic [47:0]    LCG_MUL    = 48'h5DEECE66D;
    localparam logic [3:0]     LCG_ADD    = 4'hB;
    localparam logic [15:0]    SEED_LOW   = 16'h330E;
    localparam logic [31:0]    SEED_X_MUL = 32'd21804;
    localparam logic [31:0]    SEED_Y_MUL = 32'd1290847;
    localparam logic [H_W-1:0] H_MIN      = 16'h8000;
    localparam logic [H_W-1:0] H_MAX      = 16'h7FFF;

    typedef enum logic [1:0] {
        REG_WORLD_SEED      = 2'd0,
        REG_DISTANCE_GAIN   = 2'd1,
        REG_DIFFERENCE_GAIN = 2'd2,
        REG_RANDOM_GAIN     = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_16 = 2'd1,
        SH_32 = 2'd2
    } t_mac_shift;

    typedef struct packed {
        logic       en;
        logic       load;
        logic [3:0] init;
        logic [47:0] a;
        logic [15:0] b;
        t_mac_shift sh;
    } t_mac_cmd;

    typedef struct packed {
        logic [CW-1:0] x1;
        logic [CW-1:0] y1;
        logic [CW-1:0] x2;
        logic [CW-1:0] y2;
    } t_patch;

    typedef struct packed {
        t_patch     p;
        logic [1:0] child;
    } t_frame;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic [ADDR_W-1:0] addr_t;
        logic [CW-1:0]     dx;
        logic [CW-1:0]     dy;
        logic [CW-1:0]     px;
        logic [CW-1:0]     py;
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_PATCH,
        ST_OPSEL,
        ST_RDA,
        ST_RDB,
        ST_RDW,
        ST_CALC,
        ST_POP,
        ST_EMIT_RD,
        ST_EMIT_LATCH,
        ST_EMIT_HOLD
    } t_state;

    typedef enum logic [4:0] {
        S_SEED_X,
        S_SEED_YLO,
        S_SEED_YHI,
        S_RESEED0,
        S_LCG0_A,
        S_LCG0_B,
        S_LCG0_C,
        S_RESEED1,
        S_LCG1_A,
        S_LCG1_B,
        S_LCG1_C,
        S_DRAW1,
        S_LCG2_A,
        S_LCG2_B,
        S_LCG2_C,
        S_DRAW2,
        S_SCALE_A,
        S_SCALE_B,
        S_SCALE_SUM,
        S_PROD_LO,
        S_PROD_HI,
        S_SIGN,
        S_WRITE
    } t_step;

    typedef logic [15:0] t_root_rom [ROOT_DEPTH];

    // floor(sqrt(d2) * 4096) for every squared distance index
    function automatic t_root_rom build_root();
        t_root_rom   rom;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] t;
        for (int d = 0; d < ROOT_DEPTH; d++) begin
            v = 64'(d) << 24;
            r = '0;
            for (int b = 16; b >= 0; b--) begin
                t = r + (64'd1 << b);
                if (t * t <= v) begin
                    r = t;
                end
            end
            rom[d] = r[15:0];
        end
        return rom;
    endfunction

    localparam t_root_rom ROOT_ROM = build_root();

    function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
        logic [CW:0] s;
        s = {1'b0, lo} + {1'b0, hi};
        return s[CW:1];
    endfunction

    function automatic t_patch child_patch(input t_patch p, input logic [1:0] k);
        t_patch        c;
        logic [CW-1:0] mx;
        logic [CW-1:0] my;
        mx = mid_of(p.x1, p.x2);
        my = mid_of(p.y1, p.y2);
        c  = p;
        unique case (k)
            2'd0: begin c.x2 = mx; c.y2 = my; end
            2'd1: begin c.x1 = mx; c.y2 = my; end
            2'd2: begin c.x1 = mx; c.y1 = my; end
            2'd3: begin c.x2 = mx; c.y1 = my; end
        endcase
        return c;
    endfunction

    // Endpoints, target and seed coordinates of displacement j inside patch p
    function automatic t_op op_info(input t_patch p, input logic [2:0] j);
        t_op           o;
        logic [1:0]    q1;
        logic [1:0]    q2;
        logic [CW-1:0] mx;
        logic [CW-1:0] my;
        logic [CW-1:0] tx;
        logic [CW-1:0] ty;
        logic [CW-1:0] ax;
        logic [CW-1:0] ay;
        logic [CW-1:0] bx;
        logic [CW-1:0] by;
        logic          xmid;
        logic          ymid;
        mx   = mid_of(p.x1, p.x2);
        my   = mid_of(p.y1, p.y2);
        xmid = (mx != p.x1) && (mx != p.x2);
        ymid = (my != p.y1) && (my != p.y2);
        unique case (j)
            3'd0: begin q1 = 2'd0; q2 = 2'd3; tx = mx;   ty = my;   o.valid = 1'b1; end
            3'd1: begin q1 = 2'd0; q2 = 2'd2; tx = p.x1; ty = my;   o.valid = ymid; end
            3'd2: begin q1 = 2'd1; q2 = 2'd3; tx = p.x2; ty = my;   o.valid = ymid; end
            3'd3: begin q1 = 2'd0; q2 = 2'd1; tx = mx;   ty = p.y1; o.valid = xmid; end
            3'd4: begin q1 = 2'd2; q2 = 2'd3; tx = mx;   ty = p.y2; o.valid = xmid; end
            default: begin
                q1 = 2'd0; q2 = 2'd0; tx = '0; ty = '0; o.valid = 1'b0;
            end
        endcase
        ax = q1[0] ? p.x2 : p.x1;
        ay = q1[1] ? p.y2 : p.y1;
        bx = q2[0] ? p.x2 : p.x1;
        by = q2[1] ? p.y2 : p.y1;
        o.addr_a = {ax, ay};
        o.addr_b = {bx, by};
        o.addr_t = {tx, ty};
        o.dx     = (q1[0] != q2[0]) ? (p.x2 - p.x1) : '0;
        o.dy     = (q1[1] != q2[1]) ? (p.y2 - p.y1) : '0;
        o.px     = ax;
        o.py     = by;
        return o;
    endfunction

endpackage

/* design/midpoint_displacement_heightmap_core.sv */
// Sequence: the grid is filled, then each displaced point is computed (88 points per grid), skipped
// edge points and patch visits are stepped over, and each cell is then emitted while the sink is
// ready.
// Throughput: one request at a time; the next is taken after the last cell is delivered.
// The pace is set by the single shared multiply-accumulate unit and the single-read-port grid RAM.
// Reset is synchronous, active low: control, generator state and registers return to defaults.
// Depends on mdh_pkg, mdh_ram, mdh_mac and the assertion macro header.
`include "midpoint_displacement_heightmap_core_assert.svh"

module midpoint_displacement_heightmap_core
    import mdh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: corner_nw[15:0], corner_ne[31:16], corner_sw[47:32], corner_se[63:48],
    //        origin_x[75:64], origin_y[87:76]
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [87:0] i_s_axis_tdata,
    // tdata: cell_x[2:0], cell_y[5:3], cell_height[21:6], zero fill [23:22]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // register file
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [31:0] r_world_seed;
    logic [14:0] r_distance_gain;
    logic [14:0] r_difference_gain;
    logic [14:0] r_random_gain;
    logic        w_cfg_wr;
    t_reg_idx    w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_world_seed      <= '0;
            r_distance_gain   <= 15'd123;
            r_difference_gain <= 15'd205;
            r_random_gain     <= 15'd82;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_WORLD_SEED:      r_world_seed      <= pwdata;
                REG_DISTANCE_GAIN:   r_distance_gain   <= pwdata[14:0];
                REG_DIFFERENCE_GAIN: r_difference_gain <= pwdata[14:0];
                REG_RANDOM_GAIN:     r_random_gain     <= pwdata[14:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_WORLD_SEED:      prdata = r_world_seed;
            REG_DISTANCE_GAIN:   prdata = {17'd0, r_distance_gain};
            REG_DIFFERENCE_GAIN: prdata = {17'd0, r_difference_gain};
            REG_RANDOM_GAIN:     prdata = {17'd0, r_random_gain};
        endcase
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state r_state, n_state;
    t_step  r_step,  n_step;
    logic [SP_W-1:0]   r_sp,   n_sp;
    logic [2:0]        r_op,   n_op;
    logic [ADDR_W-1:0] r_fcnt, n_fcnt;
    logic [CW-1:0]     r_ex,   n_ex;
    logic [CW-1:0]     r_ey,   n_ey;
    logic              r_out_valid, n_out_valid;
    logic [47:0]       r_gen,  n_gen;

    t_frame r_stack [STACK_DEPTH];
    t_frame n_stack [STACK_DEPTH];
    t_patch r_cur, n_cur;

    logic [H_W-1:0] r_nw, r_ne, r_sw, r_se;
    logic [11:0]    r_ox, r_oy;
    logic [H_W-1:0] r_ha, n_ha;
    logic [H_W-1:0] r_hb, n_hb;
    logic [15:0]    r_diff, n_diff;
    logic [15:0]    r_dist, n_dist;
    logic [31:0]    r_u1, n_u1;
    logic [31:0]    r_dabs, n_dabs;
    logic           r_dneg, n_dneg;
    logic [20:0]    r_scale, n_scale;
    logic [63:0]    r_prod, n_prod;

    logic [CW-1:0]  r_out_x, n_out_x;
    logic [CW-1:0]  r_out_y, n_out_y;
    logic [H_W-1:0] r_out_h, n_out_h;
    logic           r_out_last, n_out_last;

    // ------------------------------------------------------------------
    // Grid RAM and shared arithmetic unit
    // ------------------------------------------------------------------
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [H_W-1:0]    w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [H_W-1:0]    w_rdata;
    t_mac_cmd          w_mac;
    logic [63:0]       w_acc;

    mdh_ram #(
        .WIDTH (H_W),
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    mdh_mac u_mac (
        .i_clk (i_clk),
        .i_cmd (w_mac),
        .o_acc (w_acc)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    t_op            w_op;
    logic           w_stop;
    logic [CW-1:0]  w_top_idx;
    t_frame         w_top;
    logic [6:0]     w_d2;
    logic [16:0]    w_hdelta;
    logic [16:0]    w_hsum;
    logic [63:0]    w_n;
    logic signed [31:0] w_q;
    logic [H_W-1:0] w_hsat;
    logic [12:0]    w_sx;
    logic [12:0]    w_sy;
    logic [31:0]    w_u2;
    logic [CW-1:0]  w_fx;
    logic [CW-1:0]  w_fy;
    logic [H_W-1:0] w_fill;

    assign w_op      = op_info(r_cur, r_op);
    assign w_stop    = ({1'b0, r_cur.x1} + 1'b1 >= {1'b0, r_cur.x2}) &&
                       ({1'b0, r_cur.y1} + 1'b1 >= {1'b0, r_cur.y2});
    assign w_top_idx = CW'(r_sp - 1'b1);
    assign w_top     = r_stack[w_top_idx];
    assign w_d2      = 7'(w_op.dx) * 7'(w_op.dx) + 7'(w_op.dy) * 7'(w_op.dy);
    assign w_hdelta  = {r_ha[H_W-1], r_ha} - {r_hb[H_W-1], r_hb};
    assign w_hsum    = {r_ha[H_W-1], r_ha} + {r_hb[H_W-1], r_hb};
    assign w_sx      = 13'(w_op.px) + 13'(r_ox);
    assign w_sy      = 13'(w_op.py) + 13'(r_oy);
    assign w_u2      = w_acc[47:16];

    // floor(n / 2^32) of the Q32.32 mean plus scaled draw difference
    assign w_n = {{16{w_hsum[16]}}, w_hsum, 31'd0} + r_prod;
    assign w_q = signed'(w_n[63:32]);

    always_comb begin
        if (w_q < -32'sd32768) begin
            w_hsat = H_MIN;
        end else if (w_q > 32'sd32767) begin
            w_hsat = H_MAX;
        end else begin
            w_hsat = w_q[H_W-1:0];
        end
    end

    // Clear value everywhere but at the four corners
    assign w_fx = r_fcnt[ADDR_W-1:CW];
    assign w_fy = r_fcnt[CW-1:0];

    always_comb begin
        priority if (w_fx == '0 && w_fy == '0) begin
            w_fill = r_nw;
        end else if (w_fx == G_LAST && w_fy == '0) begin
            w_fill = r_ne;
        end else if (w_fx == '0 && w_fy == G_LAST) begin
            w_fill = r_sw;
        end else if (w_fx == G_LAST && w_fy == G_LAST) begin
            w_fill = r_se;
        end else begin
            w_fill = H_MIN;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: fill, patch walk with an explicit stack, displacement
    // micro-steps on the shared unit, then cell readout.
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_sp        = r_sp;
        n_op        = r_op;
        n_fcnt      = r_fcnt;
        n_ex        = r_ex;
        n_ey        = r_ey;
        n_out_valid = r_out_valid;
        n_gen       = r_gen;
        n_stack     = r_stack;
        n_cur       = r_cur;
        n_ha        = r_ha;
        n_hb        = r_hb;
        n_diff      = r_diff;
        n_dist      = r_dist;
        n_u1        = r_u1;
        n_dabs      = r_dabs;
        n_dneg      = r_dneg;
        n_scale     = r_scale;
        n_prod      = r_prod;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_h     = r_out_h;
        n_out_last  = r_out_last;

        w_we    = 1'b0;
        w_waddr = r_fcnt;
        w_wdata = w_fill;
        w_raddr = w_op.addr_a;
        w_mac   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_fcnt  = '0;
                    n_state = ST_FILL;
                end
            end

            ST_FILL: begin
                w_we   = 1'b1;
                n_fcnt = r_fcnt + 1'b1;
                if (r_fcnt == ADDR_W'(CELLS - 1)) begin
                    n_cur   = '{x1: '0, y1: '0, x2: G_LAST, y2: G_LAST};
                    n_sp    = '0;
                    n_state = ST_PATCH;
                end
            end

            ST_PATCH: begin
                n_op = '0;
                if (w_stop) begin
                    n_state = ST_POP;
                end else begin
                    n_state = ST_OPSEL;
                end
            end

            ST_OPSEL: begin
                priority if (r_op == 3'(OP_COUNT)) begin
                    // push the parent, descend into the first quadrant
                    n_stack[r_sp[CW-1:0]] = '{p: r_cur, child: 2'd0};
                    n_sp    = r_sp + 1'b1;
                    n_cur   = child_patch(r_cur, 2'd0);
                    n_state = ST_PATCH;
                end else if (w_op.valid) begin
                    n_state = ST_RDA;
                end else begin
                    n_op = r_op + 1'b1;
                end
            end

            ST_RDA: begin
                w_raddr = w_op.addr_a;
                n_state = ST_RDB;
            end

            ST_RDB: begin
                w_raddr = w_op.addr_b;
                n_ha    = w_rdata;
                n_state = ST_RDW;
            end

            ST_RDW: begin
                n_hb    = w_rdata;
                n_step  = S_SEED_X;
                n_state = ST_CALC;
            end

            ST_CALC: begin
                n_step = t_step'(r_step + 5'd1);
                unique case (r_step)
                    S_SEED_X: begin
                        n_diff = w_hdelta[16] ? 16'(-w_hdelta) : w_hdelta[15:0];
                        n_dist = ROOT_ROM[w_d2];
                        w_mac  = '{en: 1'b1, load: 1'b1, init: 4'd0, a: 48'(w_sx),
                                   b: SEED_X_MUL[15:0], sh: SH_0};
                    end
                    S_SEED_YLO: begin
                        w_mac = '{en: 1'b1, load: 1'b0, init: 4'd0, a: 48'(w_sy),
                                  b: SEED_Y_MUL[15:0], sh: SH_0};
                    end
                    S_SEED_YHI: begin
                        w_mac = '{en: 1'b1, load: 1'b0, init: 4'd0, a: 48'(w_sy),
                                  b: SEED_Y_MUL[31:16], sh: SH_16};
                    end
                    S_RESEED0: begin
                        n_gen = {w_acc[31:0], SEED_LOW};
                    end
                    S_LCG0_A, S_LCG1_A, S_LCG2_A: begin
                        w_mac = '{en: 1'b1, load: 1'b1, init: LCG_ADD, a: r_gen,
                                  b: LCG_MUL[15:0], sh: SH_0};
                    end
                    S_LCG0_B, S_LCG1_B, S_LCG2_B: begin
                        w_mac = '{en: 1'b1, load: 1'b0, init: 4'd0, a: r_gen,
                                  b: LCG_MUL[31:16], sh: SH_16};
                    end
                    S_LCG0_C, S_LCG1_C, S_LCG2_C: begin
                        w_mac = '{en: 1'b1, load: 1'b0, init: 4'd0, a: r_gen,
                                  b: LCG_MUL[47:32], sh: SH_32};
                    end
                    S_RESEED1: begin
                        // integer draw plus world seed becomes the second seed
                        n_gen = {r_world_seed + {1'b0, w_acc[47:17]}, SEED_LOW};
                    end
                    S_DRAW1: begin
                        n_gen = w_acc[47:0];
                        n_u1  = w_acc[47:16];
                    end
                    S_DRAW2: begin
                        n_gen  = w_acc[47:0];
                        n_dneg = r_u1 < w_u2;
                        n_dabs = (r_u1 < w_u2) ? (w_u2 - r_u1) : (r_u1 - w_u2);
                    end
                    S_SCALE_A: begin
                        w_mac = '{en: 1'b1, load: 1'b1, init: 4'd0, a: 48'(r_dist),
                                  b: {1'b0, r_distance_gain}, sh: SH_0};
                    end
                    S_SCALE_B: begin
                        w_mac = '{en: 1'b1, load: 1'b0, init: 4'd0, a: 48'(r_diff),
                                  b: {1'b0, r_difference_gain}, sh: SH_0};
                    end
                    S_SCALE_SUM: begin
                        n_scale = w_acc[32:12] + 21'(r_random_gain);
                    end
                    S_PROD_LO: begin
                        w_mac = '{en: 1'b1, load: 1'b1, init: 4'd0, a: 48'(r_dabs),
                                  b: r_scale[15:0], sh: SH_0};
                    end
                    S_PROD_HI: begin
                        w_mac = '{en: 1'b1, load: 1'b0, init: 4'd0, a: 48'(r_dabs),
                                  b: {11'd0, r_scale[20:16]}, sh: SH_16};
                    end
                    S_SIGN: begin
                        n_prod = r_dneg ? (64'd0 - w_acc) : w_acc;
                    end
                    S_WRITE: begin
                        w_we    = 1'b1;
                        w_waddr = w_op.addr_t;
                        w_wdata = w_hsat;
                        n_op    = r_op + 1'b1;
                        n_state = ST_OPSEL;
                    end
                    default: begin
                        n_state = ST_OPSEL;
                    end
                endcase
            end

            ST_POP: begin
                priority if (r_sp == '0) begin
                    n_ex    = '0;
                    n_ey    = '0;
                    n_state = ST_EMIT_RD;
                end else if (w_top.child == 2'd3) begin
                    n_sp = r_sp - 1'b1;
                end else begin
                    n_stack[w_top_idx].child = w_top.child + 1'b1;
                    n_cur   = child_patch(w_top.p, w_top.child + 1'b1);
                    n_state = ST_PATCH;
                end
            end

            ST_EMIT_RD: begin
                w_raddr = {r_ex, r_ey};
                n_state = ST_EMIT_LATCH;
            end

            ST_EMIT_LATCH: begin
                n_out_x     = r_ex;
                n_out_y     = r_ey;
                n_out_h     = w_rdata;
                n_out_last  = (r_ex == G_LAST) && (r_ey == G_LAST);
                n_out_valid = 1'b1;
                n_state     = ST_EMIT_HOLD;
            end

            ST_EMIT_HOLD: begin
                if (i_m_axis_tready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        // column by column: y inner, x outer
                        if (r_ey == G_LAST) begin
                            n_ey = '0;
                            n_ex = r_ex + 1'b1;
                        end else begin
                            n_ey = r_ey + 1'b1;
                        end
                        n_state = ST_EMIT_RD;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= S_SEED_X;
            r_sp        <= '0;
            r_op        <= '0;
            r_fcnt      <= '0;
            r_ex        <= '0;
            r_ey        <= '0;
            r_out_valid <= 1'b0;
            r_gen       <= '0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_sp        <= n_sp;
            r_op        <= n_op;
            r_fcnt      <= n_fcnt;
            r_ex        <= n_ex;
            r_ey        <= n_ey;
            r_out_valid <= n_out_valid;
            r_gen       <= n_gen;
        end
    end

    // Payload registers: hold the item's corners and origin on accept
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_s_axis_tvalid) begin
            r_nw <= i_s_axis_tdata[15:0];
            r_ne <= i_s_axis_tdata[31:16];
            r_sw <= i_s_axis_tdata[47:32];
            r_se <= i_s_axis_tdata[63:48];
            r_ox <= i_s_axis_tdata[75:64];
            r_oy <= i_s_axis_tdata[87:76];
        end
        r_stack    <= n_stack;
        r_cur      <= n_cur;
        r_ha       <= n_ha;
        r_hb       <= n_hb;
        r_diff     <= n_diff;
        r_dist     <= n_dist;
        r_u1       <= n_u1;
        r_dabs     <= n_dabs;
        r_dneg     <= n_dneg;
        r_scale    <= n_scale;
        r_prod     <= n_prod;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_h    <= n_out_h;
        r_out_last <= n_out_last;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_h, r_out_y, r_out_x};
    assign o_m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MDH_ASSERT_IMP(a_no_accept_while_emitting, i_clk, i_rst_n,
        o_s_axis_tready, !o_m_axis_tvalid, "item accepted while a cell is pending")
    `MDH_ASSERT_IMP(a_stack_bound, i_clk, i_rst_n,
        1'b1, r_sp <= SP_W'(STACK_DEPTH), "patch stack overflow")
    `MDH_ASSERT_IMP(a_last_is_corner, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tlast,
        r_out_x == G_LAST && r_out_y == G_LAST, "last flag on a cell other than the final one")
    `MDH_ASSERT_NXT(a_ready_after_last, i_clk, i_rst_n,
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast,
        o_s_axis_tready, "block not ready after the final cell")

endmodule

/* design/mdh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the height grid.
module mdh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/mdh_mac.sv */
// Shared 48x16 multiply-accumulate unit with a 64-bit accumulator.
// Depends on mdh_pkg for the command struct; runs the generator, seed and scale math.
module mdh_mac
    import mdh_pkg::*;
(
    input  logic        i_clk,
    input  t_mac_cmd    i_cmd,
    output logic [63:0] o_acc
);

    logic [63:0] r_acc;
    logic [63:0] w_prod;
    logic [63:0] w_term;
    logic [63:0] w_base;

    assign w_prod = 64'(i_cmd.a) * 64'(i_cmd.b);
    assign w_base = i_cmd.load ? 64'(i_cmd.init) : r_acc;

    always_comb begin
        unique case (i_cmd.sh)
            SH_0:    w_term = w_prod;
            SH_16:   w_term = w_prod << 16;
            SH_32:   w_term = w_prod << 32;
            default: w_term = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_acc <= w_base + w_term;
        end
    end

    assign o_acc = r_acc;

endmodule

/* test/midpoint_displacement_heightmap_core_tb.sv */
// Self-checking testbench for the midpoint displacement height grid core.
// Predicts every emitted cell in SystemVerilog and compares the stream; needs mdh_pkg and the core.
`timescale 1ns / 1ps

module midpoint_displacement_heightmap_core_tb;
    import mdh_pkg::*;

    localparam int N = 8;

    typedef struct {
        int h[4];
        int x1;
        int x2;
        int y1;
        int y2;
    } t_tile;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    midpoint_displacement_heightmap_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the registers, grid and generator
    logic [31:0] seed_reg = 32'd0;
    int unsigned dist_gain = 123;
    int unsigned diff_gain = 205;
    int unsigned rand_gain = 82;
    int          org_x;
    int          org_y;
    int          grid_h[N][N];
    logic [47:0] lcg;

    // Expected cells: {last, tdata}
    logic [24:0] cell_q[$];
    int          mismatches = 0;

    // Sink control: only the sink process drives m_tready
    bit  quiet_sink = 1'b0;
    bit  hold_go = 1'b0;
    bit  hold_seen = 1'b0;
    int  hold_len = 0;
    int  hold_cnt = 0;
    int  stall_cnt = 0;
    bit  quiet_source = 1'b0;

    function automatic int unsigned root_q12(int unsigned d2);
        longint unsigned v;
        longint unsigned r;
        longint unsigned t;
        v = longint'(d2) << 24;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r + (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return int'(r);
    endfunction

    function automatic logic [47:0] lcg_next(logic [47:0] st);
        return st * LCG_MUL + 48'd11;
    endfunction

    // New height between endpoint quadrants q1 and q2 of tile t
    function automatic int displaced(t_tile t, int q1, int q2);
        int              dx;
        int              dy;
        int              a;
        int              b;
        longint unsigned scale;
        logic [31:0]     px;
        logic [31:0]     py;
        logic [31:0]     s0;
        logic [31:0]     s1;
        longint          u1;
        longint          u2;
        longint          n;
        longint          q;
        dx = ((q1 & 1) != (q2 & 1)) ? t.x2 - t.x1 : 0;
        dy = ((q1 >> 1) != (q2 >> 1)) ? t.y2 - t.y1 : 0;
        a = t.h[q1];
        b = t.h[q2];
        scale = ((longint'(root_q12(dx * dx + dy * dy)) * dist_gain +
                  longint'(a > b ? a - b : b - a) * diff_gain) >> 12) + rand_gain;
        px = (q1 & 1) ? t.x2 : t.x1;
        py = (q2 & 2) ? t.y2 : t.y1;
        s0 = (px + org_x) * SEED_X_MUL + (py + org_y) * SEED_Y_MUL;
        lcg = lcg_next({s0, SEED_LOW});
        s1 = seed_reg + {1'b0, lcg[47:17]};
        lcg = lcg_next({s1, SEED_LOW});
        u1 = lcg[47:16];
        lcg = lcg_next(lcg);
        u2 = lcg[47:16];
        n = longint'(a + b) * 64'sd2147483648 + longint'(scale) * (u1 - u2);
        q = n >>> 32;
        if (q < -32768) q = -32768;
        if (q > 32767) q = 32767;
        return int'(q);
    endfunction

    function automatic void refine(t_tile s);
        int    mx;
        int    my;
        t_tile c;
        if (s.x1 >= s.x2 - 1 && s.y1 >= s.y2 - 1) return;
        mx = (s.x1 + s.x2) / 2;
        my = (s.y1 + s.y2) / 2;
        grid_h[mx][my] = displaced(s, 0, 3);
        if (my != s.y1 && my != s.y2) begin
            grid_h[s.x1][my] = displaced(s, 0, 2);
            grid_h[s.x2][my] = displaced(s, 1, 3);
        end
        if (mx != s.x1 && mx != s.x2) begin
            grid_h[mx][s.y1] = displaced(s, 0, 1);
            grid_h[mx][s.y2] = displaced(s, 2, 3);
        end
        // Visit the four quarters: nw, ne, se, sw, reading corners from the grid
        c = s;
        c.x2 = mx; c.y2 = my;
        c.h[1] = grid_h[mx][s.y1]; c.h[2] = grid_h[s.x1][my]; c.h[3] = grid_h[mx][my];
        refine(c);
        c.x1 = mx; c.x2 = s.x2;
        c.h[0] = c.h[1]; c.h[2] = c.h[3];
        c.h[1] = grid_h[s.x2][s.y1]; c.h[3] = grid_h[s.x2][my];
        refine(c);
        c.y1 = my; c.y2 = s.y2;
        c.h[0] = c.h[2]; c.h[1] = c.h[3];
        c.h[2] = grid_h[mx][s.y2]; c.h[3] = grid_h[s.x2][s.y2];
        refine(c);
        c.x1 = s.x1; c.x2 = mx;
        c.h[1] = c.h[0]; c.h[3] = c.h[2];
        c.h[0] = grid_h[s.x1][my]; c.h[2] = grid_h[s.x1][s.y2];
        refine(c);
    endfunction

    // Build the grid for one request and queue its 64 cells in emit order
    function automatic void predict_grid(logic [87:0] req);
        t_tile t;
        org_x = req[75:64];
        org_y = req[87:76];
        foreach (grid_h[i, j]) grid_h[i][j] = -32768;
        for (int k = 0; k < 4; k++) t.h[k] = int'($signed(req[16*k +: 16]));
        t.x1 = 0; t.y1 = 0; t.x2 = N - 1; t.y2 = N - 1;
        grid_h[0][0] = t.h[0];
        grid_h[N-1][0] = t.h[1];
        grid_h[0][N-1] = t.h[2];
        grid_h[N-1][N-1] = t.h[3];
        refine(t);
        for (int x = 0; x < N; x++)
            for (int y = 0; y < N; y++)
                cell_q.push_back({1'(x == N - 1 && y == N - 1), 2'b00,
                                  16'(grid_h[x][y]), 3'(y), 3'(x)});
    endfunction

    // Sink: random stalls, quiet stretches and an occasional long hold-off
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_cnt <= hold_len;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            m_tready <= 1'b0;
        end else if (quiet_sink) begin
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            m_tready <= (r >= 10);
            if (r == 0) stall_cnt <= $urandom_range(20, 80);
            else if (r < 10) stall_cnt <= $urandom_range(0, 2);
        end
    end

    // Check each delivered cell against the oldest expectation
    always @(posedge i_clk) begin
        logic [24:0] want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (cell_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected cell: tdata=%h tlast=%b", m_tdata, m_tlast);
            end else begin
                want = cell_q.pop_front();
                if (want[2:0] !== m_tdata[2:0] || want[5:3] !== m_tdata[5:3] ||
                    want[21:6] !== m_tdata[21:6] || want[24] !== m_tlast) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("cell mismatch: exp x=%0d y=%0d h=%h last=%b, got x=%0d y=%0d h=%h last=%b",
                                 want[2:0], want[5:3], want[21:6], want[24],
                                 m_tdata[2:0], m_tdata[5:3], m_tdata[21:6], m_tlast);
                end
            end
        end
    end

    // Offer one request after a random gap; predict once it is taken
    task automatic send_request(logic [87:0] req);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        gap = quiet_source ? 0 : (r < 5 ? $urandom_range(10, 40) : $urandom_range(0, 2));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= req;
        do @(posedge i_clk); while (!s_tready);
        predict_grid(req);
    endtask

    // Drop valid and wait until every expected cell is out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (cell_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic reg_write(t_reg_idx idx, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 4'(idx) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        unique case (idx)
            REG_WORLD_SEED:      seed_reg = value;
            REG_DISTANCE_GAIN:   dist_gain = value[14:0];
            REG_DIFFERENCE_GAIN: diff_gain = value[14:0];
            REG_RANDOM_GAIN:     rand_gain = value[14:0];
        endcase
    endtask

    task automatic set_gains(logic [31:0] seed, logic [31:0] dg, logic [31:0] fg,
                             logic [31:0] rg);
        reg_write(REG_WORLD_SEED, seed);
        reg_write(REG_DISTANCE_GAIN, dg);
        reg_write(REG_DIFFERENCE_GAIN, fg);
        reg_write(REG_RANDOM_GAIN, rg);
    endtask

    function automatic logic [87:0] pack_req(logic [15:0] nw, logic [15:0] ne,
                                             logic [15:0] sw, logic [15:0] se,
                                             logic [11:0] ox, logic [11:0] oy);
        return {oy, ox, se, sw, ne, nw};
    endfunction

    function automatic logic [15:0] rand_height();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7FFF;
        return 16'($urandom);
    endfunction

    function automatic logic [87:0] rand_req();
        return pack_req(rand_height(), rand_height(), rand_height(), rand_height(),
                        12'($urandom), 12'($urandom));
    endfunction

    // Corner and origin extremes under the reset gains
    task automatic test_default_gains();
        send_request(pack_req(16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd0, 12'd0));
        send_request(pack_req(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 12'hFFF, 12'hFFF));
        send_request(pack_req(16'h8000, 16'h8000, 16'h8000, 16'h8000, 12'd0, 12'hFFF));
        send_request(pack_req(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 12'hFFF, 12'd0));
        send_request(pack_req(16'hFFFF, 16'h0001, 16'h1000, 16'hF000, 12'h555, 12'hAAA));
        drain();
    endtask

    // Register extremes, with stray upper bits that must be ignored
    task automatic test_register_extremes();
        set_gains(32'd0, 32'd0, 32'd0, 32'd0);
        send_request(pack_req(16'h7FFF, 16'h8000, 16'h1234, 16'hEDCB, 12'd7, 12'd9));
        send_request(pack_req(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 12'd0, 12'd0));
        drain();
        set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(pack_req(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 12'hFFF, 12'hFFF));
        send_request(pack_req(16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd0, 12'd0));
        send_request(pack_req(16'h8000, 16'h8000, 16'h8000, 16'h8000, 12'd1, 12'd2));
        drain();
        set_gains(32'h8000_0001, 32'hFFFF_8000, 32'h0000_7FFF, 32'h0001_0001);
        send_request(pack_req(16'h4000, 16'hC000, 16'h0FFF, 16'hF001, 12'h800, 12'h7FF));
        send_request(rand_req());
        drain();
    endtask

    // Long sink hold-off while requests keep coming, so the core backs up
    task automatic test_sink_holdoff();
        hold_len = 3000;
        hold_go = ~hold_go;
        quiet_source = 1'b1;
        repeat (4) send_request(rand_req());
        quiet_source = 1'b0;
        drain();
    endtask

    // Random requests over several random register settings
    task automatic test_random_grids(int count);
        for (int p = 0; p < 4; p++) begin
            set_gains($urandom, $urandom_range(0, 32767), $urandom_range(0, 32767),
                      $urandom_range(0, 32767));
            quiet_sink = (p == 1);
            quiet_source = (p == 1);
            for (int k = 0; k < count / 4; k++) send_request(rand_req());
            drain();
        end
        quiet_sink = 1'b0;
        quiet_source = 1'b0;
        // Return to the reset gains for a final batch
        set_gains(32'd0, 32'd123, 32'd205, 32'd82);
        for (int k = 0; k < 10; k++) send_request(rand_req());
        drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_gains();
        test_register_extremes();
        test_sink_holdoff();
        test_random_grids(340);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && cell_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
